// ===== sv/ogrf_pkg.sv =====
// ----------------------------------------------------------------------------
// ogrf_pkg: shared types for the occupancy grid
// Holds the command codes, the register indexes and the row memory control
// group used by the grid controller and its row store.
// ----------------------------------------------------------------------------
package ogrf_pkg;

	// Command carried by one input beat.
	typedef enum logic [1:0] {
		KIND_QUERY    = 2'd0,
		KIND_MARK_OCC = 2'd1,
		KIND_MARK_FREE = 2'd2,
		KIND_FILL     = 2'd3
	} kind_t;

	// Configuration register indexes.
	typedef enum logic {
		REG_ROWS_IN_USE    = 1'b0,
		REG_COLUMNS_IN_USE = 1'b1
	} reg_index_t;

	// Width of the configuration registers.
	localparam int CFG_W = 7;

	// Control group from the sequencer to the row store.
	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} mem_ctrl_t;

endpackage

// ===== sv/occupancy_grid_rect_fill.sv =====
// ----------------------------------------------------------------------------
// occupancy_grid_rect_fill: one-bit-per-cell occupancy grid
// Queries, marks and clears single cells, and fills clipped rectangles as
// occupied one row per cycle through a read-modify-write row pipeline.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                 Payload
// command   in         start & !busy             kind, row_a, column_a, row_b, column_b
// result    out        done (one-cycle strobe)   cell_free, inside_grid
// config    in         cfg_we                    cfg_index, cfg_data
//
// A cell query or cell write reads its row in S_PREP and checks or writes the
// cell in S_CELL, then strobes done; outside the grid in use it strobes done
// from S_PREP. A rectangle streams its clipped rows through the single row store
// port pair, one row read and one row written per cycle; an empty one strobes done from S_PREP.
// After reset the grid reads free at once; row valid bits replace a clear pass.
// The receiver cannot stall: each result is on the ports for one cycle only.
// ----------------------------------------------------------------------------
module occupancy_grid_rect_fill #(
	parameter int MAX_ROWS    = 64,
	parameter int MAX_COLUMNS = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// Command beat
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   kind,
	input  logic signed [7:0]            row_a,
	input  logic signed [7:0]            column_a,
	input  logic signed [7:0]            row_b,
	input  logic signed [7:0]            column_b,
	// Result beat
	output logic                         done,
	output logic                         cell_free,
	output logic                         inside_grid,
	// Configuration writes
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [ogrf_pkg::CFG_W-1:0]   cfg_data
);
	import ogrf_pkg::*;

	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam logic [CFG_W-1:0] ROWS_LIMIT = CFG_W'(MAX_ROWS);
	localparam logic [CFG_W-1:0] COLS_LIMIT = CFG_W'(MAX_COLUMNS);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_PREP = 4'b0010,
		S_CELL = 4'b0100,
		S_FILL = 4'b1000
	} state_t;

	state_t               state_q;
	logic [CFG_W-1:0]     rows_in_use_q;
	logic [CFG_W-1:0]     columns_in_use_q;
	logic [CFG_W-1:0]     eff_rows;
	logic [CFG_W-1:0]     eff_cols;

	// Latched command
	kind_t                kind_q;
	logic signed [7:0]    ra_q;
	logic signed [7:0]    ca_q;
	logic signed [7:0]    rb_q;
	logic signed [7:0]    cb_q;
	logic                 in_a_q;
	logic                 in_a_d;

	// Rectangle clipping
	logic signed [8:0]    ra_x, ca_x, rb_x, cb_x;
	logic signed [8:0]    lim_r, lim_c;
	logic signed [8:0]    r0, r1, c0, c1;
	logic                 fill_ok;
	logic [MAX_COLUMNS-1:0] mask_d;

	// Fill pipeline
	logic [MAX_COLUMNS-1:0] mask_q;
	logic [RW-1:0]        rd_row_q;
	logic [RW-1:0]        last_row_q;
	logic [RW-1:0]        wr_row_q;
	logic                 rd_more_q;
	logic                 pend_q;

	// Result registers
	logic                 done_q;
	logic                 cell_free_q;
	logic                 inside_q;

	// Row store interface
	mem_ctrl_t            mem_ctrl;
	logic [RW-1:0]        mem_rd_addr;
	logic [RW-1:0]        mem_wr_addr;
	logic [MAX_COLUMNS-1:0] mem_wr_data;
	logic [MAX_COLUMNS-1:0] mem_rd_data;
	logic [MAX_COLUMNS-1:0] cell_bit;
	logic                 cell_occ;

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign cell_free   = cell_free_q;
	assign inside_grid = inside_q;

	// Registers above the grid size act as the grid size.
	assign eff_rows = (rows_in_use_q > ROWS_LIMIT) ? ROWS_LIMIT : rows_in_use_q;
	assign eff_cols = (columns_in_use_q > COLS_LIMIT) ? COLS_LIMIT : columns_in_use_q;

	// Inside test of the addressed cell, taken at the accept beat.
	assign in_a_d = !row_a[7] && (row_a[6:0] < eff_rows) &&
		!column_a[7] && (column_a[6:0] < eff_cols);

	// Rectangle corners clipped to the grid in use.
	assign ra_x  = {ra_q[7], ra_q};
	assign ca_x  = {ca_q[7], ca_q};
	assign rb_x  = {rb_q[7], rb_q};
	assign cb_x  = {cb_q[7], cb_q};
	assign lim_r = $signed({2'b00, eff_rows}) - 9'sd1;
	assign lim_c = $signed({2'b00, eff_cols}) - 9'sd1;
	assign r0    = ra_x[8] ? 9'sd0 : ra_x;
	assign c0    = ca_x[8] ? 9'sd0 : ca_x;
	assign r1    = (rb_x > lim_r) ? lim_r : rb_x;
	assign c1    = (cb_x > lim_c) ? lim_c : cb_x;
	assign fill_ok = (r0 <= r1) && (c0 <= c1);

	// Column mask of the clipped rectangle, one compare pair per column.
	always_comb begin
		for (int c = 0; c < MAX_COLUMNS; c++) begin
			mask_d[c] = ($signed(9'(c)) >= c0) && ($signed(9'(c)) <= c1);
		end
	end

	// Single cell selected from the row just read.
	assign cell_bit = MAX_COLUMNS'(1) << ca_q[CW-1:0];
	assign cell_occ = |(mem_rd_data & cell_bit);

	// Row store port control.
	always_comb begin
		mem_ctrl    = '0;
		mem_rd_addr = ra_q[RW-1:0];
		mem_wr_addr = ra_q[RW-1:0];
		mem_wr_data = mem_rd_data | cell_bit;
		case (state_q)
			S_PREP: begin
				if (kind_q != KIND_FILL && in_a_q) begin
					mem_ctrl.rd_en = 1'b1;
				end
			end
			S_CELL: begin
				if (kind_q == KIND_MARK_OCC) begin
					mem_ctrl.wr_en = 1'b1;
				end else if (kind_q == KIND_MARK_FREE) begin
					mem_ctrl.wr_en = 1'b1;
					mem_wr_data    = mem_rd_data & ~cell_bit;
				end
			end
			S_FILL: begin
				mem_ctrl.rd_en = rd_more_q;
				mem_ctrl.wr_en = pend_q;
				mem_rd_addr    = rd_row_q;
				mem_wr_addr    = wr_row_q;
				mem_wr_data    = mem_rd_data | mask_q;
			end
			default: begin
			end
		endcase
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_in_use_q    <= CFG_W'(64);
			columns_in_use_q <= CFG_W'(64);
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_ROWS_IN_USE:    rows_in_use_q    <= cfg_data;
				REG_COLUMNS_IN_USE: columns_in_use_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Command latch at the accept beat.
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			kind_q <= kind_t'(kind);
			ra_q   <= row_a;
			ca_q   <= column_a;
			rb_q   <= row_b;
			cb_q   <= column_b;
			in_a_q <= in_a_d;
		end
	end

	// Fill pipeline payload.
	always_ff @(posedge clk) begin
		if (state_q == S_PREP) begin
			mask_q     <= mask_d;
			last_row_q <= r1[RW-1:0];
		end
		if (state_q == S_FILL) begin
			wr_row_q <= rd_row_q;
		end
		if (state_q == S_PREP) begin
			cell_free_q <= 1'b0;
			inside_q    <= in_a_q;
		end else if (state_q == S_CELL) begin
			cell_free_q <= (kind_q == KIND_QUERY) && !cell_occ;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			done_q    <= 1'b0;
			rd_row_q  <= '0;
			rd_more_q <= 1'b0;
			pend_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					if (kind_q == KIND_FILL) begin
						if (fill_ok) begin
							rd_row_q  <= r0[RW-1:0];
							rd_more_q <= 1'b1;
							pend_q    <= 1'b0;
							state_q   <= S_FILL;
						end else begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					end else if (in_a_q) begin
						state_q <= S_CELL;
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_CELL: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_FILL: begin
					// One row read and the previous row written back each cycle.
					pend_q <= rd_more_q;
					if (rd_more_q) begin
						rd_row_q <= rd_row_q + RW'(1);
						if (rd_row_q == last_row_q) begin
							rd_more_q <= 1'b0;
						end
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	ogrf_row_mem #(
		.DEPTH (MAX_ROWS),
		.WIDTH (MAX_COLUMNS),
		.AW    (RW)
	) u_row_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (mem_ctrl),
		.rd_addr (mem_rd_addr),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_data (mem_rd_data)
	);

endmodule

// ===== sv/ogrf_row_mem.sv =====
// ----------------------------------------------------------------------------
// ogrf_row_mem: row store of the occupancy grid
// One grid row per word, one write and one registered read per cycle. A row
// valid bit per word makes the whole grid read as free right after reset.
// ----------------------------------------------------------------------------
module ogrf_row_mem #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 64,
	parameter int AW    = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ogrf_pkg::mem_ctrl_t  ctrl,
	input  logic [AW-1:0]        rd_addr,
	input  logic [AW-1:0]        wr_addr,
	input  logic [WIDTH-1:0]     wr_data,
	output logic [WIDTH-1:0]     rd_data
);
	import ogrf_pkg::*;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [WIDTH-1:0] rd_data_q;
	logic             rd_valid_q;

	// Row valid bits, cleared at reset and set by the first write of a row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (ctrl.wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (ctrl.rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	// Storage array and its registered read port.
	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (ctrl.rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// A row never written reads as all free.
	assign rd_data = rd_valid_q ? rd_data_q : '0;

endmodule

// ===== bench/occupancy_grid_rect_fill_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// occupancy_grid_rect_fill_test: self-checking bench for the occupancy grid
// Drives cell queries, cell marks and rectangle fills through the command
// port, keeps its own copy of the grid and the grid size registers, and checks
// every result beat against the expected one in order. The grid size is moved
// through empty, single-cell, clamped and odd shapes between phases.
// ----------------------------------------------------------------------------

module occupancy_grid_rect_fill_test;
	import ogrf_pkg::*;

	// Keeps a copy of the grid, predicts each result and checks the result beats.
	class grid_scoreboard;

		localparam int GRID_ROWS    = 64;
		localparam int GRID_COLUMNS = 64;

		typedef struct {
			logic cell_free;
			logic inside_grid;
		} grid_result_t;

		bit [63:0]    cell_rows [GRID_ROWS];
		int           rows_reg    = 64;
		int           columns_reg = 64;
		grid_result_t expected_results [$];

		int errors       = 0;
		int commands     = 0;
		int results      = 0;
		int queries_free = 0;
		int queries_occ  = 0;
		int fills        = 0;

		function int eff_rows();
			return (rows_reg > GRID_ROWS) ? GRID_ROWS : rows_reg;
		endfunction

		function int eff_columns();
			return (columns_reg > GRID_COLUMNS) ? GRID_COLUMNS : columns_reg;
		endfunction

		function bit in_grid(int r, int c);
			return r >= 0 && r < eff_rows() && c >= 0 && c < eff_columns();
		endfunction

		function void set_register(reg_index_t idx, int value);
			if (idx == REG_ROWS_IN_USE)
				rows_reg = value & 'h7f;
			else
				columns_reg = value & 'h7f;
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		// Applies one accepted command to the grid copy and queues its result.
		function void note_command(kind_t k, logic signed [7:0] ra8,
			logic signed [7:0] ca8, logic signed [7:0] rb8, logic signed [7:0] cb8);
			int ra, ca, rb, cb;
			int r0, c0, r1, c1;
			grid_result_t res;
			ra = int'(ra8);
			ca = int'(ca8);
			rb = int'(rb8);
			cb = int'(cb8);
			res.cell_free = 1'b0;
			res.inside_grid = in_grid(ra, ca);
			commands++;
			case (k)
				KIND_QUERY: begin
					if (res.inside_grid)
						res.cell_free = !cell_rows[ra][ca];
					if (res.cell_free)
						queries_free++;
					else
						queries_occ++;
				end
				KIND_MARK_OCC: begin
					if (res.inside_grid)
						cell_rows[ra][ca] = 1'b1;
				end
				KIND_MARK_FREE: begin
					if (res.inside_grid)
						cell_rows[ra][ca] = 1'b0;
				end
				default: begin
					// Clip the rectangle to the grid in use; an inverted one writes nothing.
					fills++;
					r0 = (ra < 0) ? 0 : ra;
					c0 = (ca < 0) ? 0 : ca;
					r1 = (rb > eff_rows() - 1) ? eff_rows() - 1 : rb;
					c1 = (cb > eff_columns() - 1) ? eff_columns() - 1 : cb;
					for (int r = r0; r <= r1; r++)
						for (int c = c0; c <= c1; c++)
							cell_rows[r][c] = 1'b1;
				end
			endcase
			expected_results = {expected_results, res};
		endfunction

		// Compares one result beat with the oldest expectation.
		function void check_result(logic got_free, logic got_inside);
			grid_result_t res;
			results++;
			if (expected_results.size() == 0) begin
				$error("result beat with no command waiting: cell_free %0b, inside_grid %0b",
					got_free, got_inside);
				errors++;
				return;
			end
			res = expected_results.pop_front();
			if (got_free !== res.cell_free) begin
				$error("cell_free: expected %0b, actual %0b", res.cell_free, got_free);
				errors++;
			end
			if (got_inside !== res.inside_grid) begin
				$error("inside_grid: expected %0b, actual %0b", res.inside_grid, got_inside);
				errors++;
			end
		endfunction

		function void report_leftovers();
			if (expected_results.size() != 0) begin
				$error("%0d results never arrived", expected_results.size());
				errors++;
			end
		endfunction

	endclass

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_ITEMS    = 110;
	localparam int NUM_PHASES     = 10;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	kind_t             kind = KIND_QUERY;
	logic signed [7:0] row_a = '0;
	logic signed [7:0] column_a = '0;
	logic signed [7:0] row_b = '0;
	logic signed [7:0] column_b = '0;
	logic              done;
	logic              cell_free;
	logic              inside_grid;
	logic              cfg_we = 1'b0;
	reg_index_t        cfg_index = REG_ROWS_IN_USE;
	logic [CFG_W-1:0]  cfg_data = '0;

	grid_scoreboard board = new;
	int             quiet_cycles = 0;
	int             settings_used = 0;

	// Grid shapes per phase: full, empty either way, single cell, clamped, strips, odd.
	int phase_rows    [NUM_PHASES] = '{64, 0, 64, 1, 127, 1, 64, 23, 100, 64};
	int phase_columns [NUM_PHASES] = '{64, 64, 0, 1, 127, 64, 1, 41, 9, 64};

	occupancy_grid_rect_fill u_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Beat monitor and watchdog, sampled at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				board.check_result(cell_free, inside_grid);
			if (start && !busy)
				board.note_command(kind, row_a, column_a, row_b, column_b);
			if (done || (start && !busy)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
				$display("occupancy_grid_rect_fill verification failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// Presents one command beat and holds it until accepted; returns at a falling edge.
	task automatic send_command(kind_t k, int ra, int ca, int rb, int cb);
		start <= 1'b1;
		kind <= k;
		row_a <= 8'(ra);
		column_a <= 8'(ca);
		row_b <= 8'(rb);
		column_b <= 8'(cb);
		do
			@(posedge clk);
		while (busy);
		@(negedge clk);
	endtask

	task automatic maybe_idle(bit allowed);
		if (allowed && $urandom_range(0, 99) < 18) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
	endtask

	// Stops sending and waits until every expected result has come back.
	task automatic drain_results();
		start <= 1'b0;
		while (board.pending() > 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	// Leaves the write enable high; the caller lowers it after the last write.
	task automatic write_register(reg_index_t idx, int value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[CFG_W-1:0];
		board.set_register(idx, value);
		@(negedge clk);
	endtask

	task automatic set_grid(int rows, int columns);
		write_register(REG_ROWS_IN_USE, rows);
		write_register(REG_COLUMNS_IN_USE, columns);
		cfg_we <= 1'b0;
		@(negedge clk);
		settings_used++;
	endtask

	// Mostly near the grid in use, sometimes anywhere in the signed range.
	function automatic int pick_coord(int span);
		int coord;
		if ($urandom_range(0, 99) < 80)
			coord = int'($urandom_range(0, span + 1)) - 1;
		else
			coord = int'($urandom_range(0, 255)) - 128;
		return coord;
	endfunction

	task automatic random_command();
		kind_t k;
		int    pick;
		int    ra, ca, rb, cb;
		pick = $urandom_range(0, 99);
		if (pick < 35)
			k = KIND_QUERY;
		else if (pick < 58)
			k = KIND_MARK_OCC;
		else if (pick < 85)
			k = KIND_MARK_FREE;
		else
			k = KIND_FILL;
		ra = pick_coord(board.eff_rows());
		ca = pick_coord(board.eff_columns());
		rb = int'($urandom_range(0, 255)) - 128;
		cb = int'($urandom_range(0, 255)) - 128;
		// Fills are mostly small, sometimes inverted by one, rarely arbitrary.
		if (k == KIND_FILL && $urandom_range(0, 9) != 0) begin
			rb = ra + int'($urandom_range(0, 7)) - 1;
			cb = ca + int'($urandom_range(0, 7)) - 1;
		end
		send_command(k, ra, ca, rb, cb);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed commands on the grid size left by reset.
		send_command(KIND_QUERY, 0, 0, 0, 0);
		send_command(KIND_MARK_OCC, 0, 0, 0, 0);
		send_command(KIND_QUERY, 0, 0, 0, 0);
		send_command(KIND_MARK_OCC, 63, 63, 0, 0);
		send_command(KIND_QUERY, 63, 63, 0, 0);
		send_command(KIND_MARK_FREE, 63, 63, 0, 0);
		send_command(KIND_QUERY, 63, 63, 0, 0);
		send_command(KIND_QUERY, -1, 0, 0, 0);
		send_command(KIND_QUERY, 0, 64, 0, 0);
		send_command(KIND_QUERY, -128, -128, 127, 127);
		send_command(KIND_QUERY, 127, 127, -128, -128);
		send_command(KIND_MARK_OCC, 64, 5, 0, 0);
		send_command(KIND_MARK_FREE, -1, -1, 0, 0);
		// Empty rectangles: inverted rows, inverted columns, wholly outside.
		send_command(KIND_FILL, 10, 20, 9, 30);
		send_command(KIND_FILL, 10, 20, 12, 19);
		send_command(KIND_FILL, 70, 70, 100, 100);
		// Rectangle clipped at the top and on the right.
		send_command(KIND_FILL, -3, 60, 2, 127);
		send_command(KIND_QUERY, 2, 63, 0, 0);
		send_command(KIND_QUERY, 3, 63, 0, 0);
		send_command(KIND_QUERY, 0, 59, 0, 0);
		send_command(KIND_FILL, 5, 5, 5, 5);
		send_command(KIND_QUERY, 5, 5, 0, 0);
		drain_results();

		// Fill everything while the grid is small, then grow it back.
		set_grid(2, 3);
		send_command(KIND_FILL, -128, -128, 127, 127);
		send_command(KIND_QUERY, 1, 2, 0, 0);
		send_command(KIND_QUERY, 2, 0, 0, 0);
		drain_results();
		set_grid(64, 64);
		send_command(KIND_QUERY, 2, 0, 0, 0);
		send_command(KIND_QUERY, 1, 3, 0, 0);
		drain_results();

		// Random phases, one grid shape each; phase 6 runs with no sender gaps.
		for (int p = 0; p < NUM_PHASES; p++) begin
			set_grid(phase_rows[p], phase_columns[p]);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				random_command();
				if (p == 0 && i == PHASE_ITEMS / 2)
					drain_results();
				else
					maybe_idle(p != 6);
			end
			drain_results();
		end

		repeat (10) @(negedge clk);
		board.report_leftovers();
		$display("Ran %0d commands over %0d grid shapes: %0d queries (%0d free, %0d occupied),",
			board.commands, settings_used + 1, board.queries_free + board.queries_occ,
			board.queries_free, board.queries_occ);
		$display("%0d fills; checked %0d result beats, %0d mismatches.",
			board.fills, board.results, board.errors);
		if (board.errors == 0)
			$display("occupancy_grid_rect_fill verification clean");
		else
			$display("occupancy_grid_rect_fill verification failed");
		$finish;
	end

endmodule
